// ----- hw/rtl/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes of the reference-counted palette allocator: the
// table entry layout, the operation codes and the result status codes.
// ----------------------------------------------------------------------------
package rpa_pkg;

    // Operation codes carried by the func field
    localparam logic [1:0] FN_ALLOC      = 2'd0;
    localparam logic [1:0] FN_FREE_COLOR = 2'd1;
    localparam logic [1:0] FN_FREE_SLOT  = 2'd2;
    localparam logic [1:0] FN_CLEAR      = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;

    localparam int unsigned COLOR_W = 16;
    localparam int unsigned COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One table entry: colour word and use count
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

// ----- hw/rtl/refcounted_palette_allocator_core.sv -----
// Sequence: allocate and free by colour scan the table one entry a cycle;
//   free by slot reads one entry; clear all and an out-of-table free by slot
//   go straight to the result stage.
// Throughput: one operation at a time, bounded by the single table read port.
// Reset: synchronous, active low; table reads empty, error slot returns to 185.
// ----------------------------------------------------------------------------
// refcounted_palette_allocator_core
// Reference-counted palette allocator: allocate, free by colour, free by slot
// and clear all on a table of colour entries with saturating use counts.
// ----------------------------------------------------------------------------
module refcounted_palette_allocator_core #(
    parameter int ENTRIES   = 32,
    parameter int BASE_SLOT = 224
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_color,
    input  logic [7:0]  i_palette_slot,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_result_slot,
    output logic [1:0]  o_status,
    output logic [15:0] o_count_after,
    output logic        o_entry_released
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [7:0] BASE = 8'(BASE_SLOT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    // Control and request registers
    logic [1:0]    r_state, n_state;
    logic [1:0]    r_op, n_op;
    logic [15:0]   r_color, n_color;
    logic [7:0]    r_pslot, n_pslot;
    logic [CW-1:0] r_iss, n_iss;
    logic [CW-1:0] r_end, n_end;
    logic          r_rd_vld, n_rd_vld;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_have_free, n_have_free;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [7:0]    r_error_slot;

    // Pending result
    logic [7:0]    r_res_slot, n_res_slot;
    logic [1:0]    r_res_status, n_res_status;
    logic [15:0]   r_res_count, n_res_count;
    logic          r_res_rel, n_res_rel;

    // Output register
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_slot, n_out_slot;
    logic [1:0]    r_out_status, n_out_status;
    logic [15:0]   r_out_count, n_out_count;
    logic          r_out_rel, n_out_rel;

    // Table port signals
    logic            tbl_clear;
    logic            tbl_rd_en;
    logic [IW-1:0]   tbl_rd_addr;
    rpa_pkg::t_entry tbl_rd_entry;
    logic            tbl_wr_en;
    logic [IW-1:0]   tbl_wr_addr;
    rpa_pkg::t_entry tbl_wr_entry;

    logic          in_beat;
    logic [7:0]    slot_off;
    logic          slot_in_table;
    logic          d_used;
    logic          d_match;
    logic          d_last;
    logic [15:0]   dec_count;
    logic [15:0]   inc_count;

    rpa_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (tbl_clear),
        .i_rd_en    (tbl_rd_en),
        .i_rd_addr  (tbl_rd_addr),
        .o_rd_entry (tbl_rd_entry),
        .i_wr_en    (tbl_wr_en),
        .i_wr_addr  (tbl_wr_addr),
        .i_wr_entry (tbl_wr_entry)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;

    // Decode the slot of a free-by-slot request
    assign slot_off      = i_palette_slot - BASE;
    assign slot_in_table = ({1'b0, slot_off} < 9'(ENTRIES));

    // Classify the entry returned by the table
    assign d_used    = (tbl_rd_entry.count != '0);
    assign d_match   = d_used && (tbl_rd_entry.color == r_color);
    assign d_last    = ((CW'(r_rd_idx) + CW'(1)) == r_end);
    assign dec_count = tbl_rd_entry.count - 16'd1;
    assign inc_count = (tbl_rd_entry.count == rpa_pkg::COUNT_MAX) ?
                       tbl_rd_entry.count : tbl_rd_entry.count + 16'd1;

    // Sequencer: accept, scan the table, hand the result to the output stage
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_color      = r_color;
        n_pslot      = r_pslot;
        n_iss        = r_iss;
        n_end        = r_end;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_have_free  = r_have_free;
        n_free_idx   = r_free_idx;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_res_count  = r_res_count;
        n_res_rel    = r_res_rel;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_rel    = r_out_rel;
        tbl_clear    = 1'b0;
        tbl_rd_en    = 1'b0;
        tbl_rd_addr  = r_iss[IW-1:0];
        tbl_wr_en    = 1'b0;
        tbl_wr_addr  = r_rd_idx;
        tbl_wr_entry = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_op        = i_func;
                    n_color     = i_color;
                    n_pslot     = i_palette_slot;
                    n_have_free = 1'b0;
                    n_res_slot   = 8'd0;
                    n_res_status = rpa_pkg::ST_OK;
                    n_res_count  = 16'd0;
                    n_res_rel    = 1'b0;
                    case (i_func) inside
                        rpa_pkg::FN_ALLOC, rpa_pkg::FN_FREE_COLOR: begin
                            n_iss   = '0;
                            n_end   = CW'(ENTRIES);
                            n_state = S_SCAN;
                        end
                        rpa_pkg::FN_FREE_SLOT: begin
                            if (slot_in_table) begin
                                n_iss   = CW'(slot_off[IW-1:0]);
                                n_end   = CW'(slot_off[IW-1:0]) + CW'(1);
                                n_state = S_SCAN;
                            end else begin
                                n_res_slot   = i_palette_slot;
                                n_res_status = rpa_pkg::ST_NO_MATCH;
                                n_state      = S_RESP;
                            end
                        end
                        default: begin
                            tbl_clear = 1'b1;
                            n_state   = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue the next read while entries remain
                if (r_iss != r_end) begin
                    tbl_rd_en = 1'b1;
                    n_iss     = r_iss + CW'(1);
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_iss[IW-1:0];
                end
                // Evaluate the entry read last cycle
                if (r_rd_vld) begin
                    if (r_op == rpa_pkg::FN_ALLOC) begin
                        if (d_match) begin
                            tbl_wr_en          = 1'b1;
                            tbl_wr_entry.color = tbl_rd_entry.color;
                            tbl_wr_entry.count = inc_count;
                            n_res_slot  = BASE + 8'(r_rd_idx);
                            n_res_count = inc_count;
                            n_state     = S_RESP;
                        end else begin
                            if (!d_used && !r_have_free) begin
                                n_have_free = 1'b1;
                                n_free_idx  = r_rd_idx;
                            end
                            if (d_last) begin
                                n_state = S_RESP;
                                if (r_have_free || !d_used) begin
                                    tbl_wr_en          = 1'b1;
                                    tbl_wr_addr        = r_have_free ? r_free_idx : r_rd_idx;
                                    tbl_wr_entry.color = r_color;
                                    tbl_wr_entry.count = 16'd1;
                                    n_res_slot  = BASE + 8'(tbl_wr_addr);
                                    n_res_count = 16'd1;
                                end else begin
                                    n_res_slot   = r_error_slot;
                                    n_res_status = rpa_pkg::ST_FULL;
                                end
                            end
                        end
                    end else begin
                        // Free by colour or by slot: drop one user on a hit
                        if ((r_op == rpa_pkg::FN_FREE_COLOR) ? d_match : d_used) begin
                            tbl_wr_en          = 1'b1;
                            tbl_wr_entry.count = dec_count;
                            tbl_wr_entry.color = (dec_count == 16'd0) ?
                                                 16'd0 : tbl_rd_entry.color;
                            n_res_slot  = BASE + 8'(r_rd_idx);
                            n_res_count = dec_count;
                            n_res_rel   = (dec_count == 16'd0);
                            n_state     = S_RESP;
                        end else if (d_last) begin
                            n_res_slot   = (r_op == rpa_pkg::FN_FREE_SLOT) ? r_pslot : 8'd0;
                            n_res_status = rpa_pkg::ST_NO_MATCH;
                            n_state      = S_RESP;
                        end
                    end
                end
            end

            S_RESP: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_out_count  = r_res_count;
                    n_out_rel    = r_res_rel;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_error_slot <= 8'd185;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_error_slot <= i_cfg_wdata;
            end
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_color      <= n_color;
        r_pslot      <= n_pslot;
        r_iss        <= n_iss;
        r_end        <= n_end;
        r_rd_idx     <= n_rd_idx;
        r_have_free  <= n_have_free;
        r_free_idx   <= n_free_idx;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_res_count  <= n_res_count;
        r_res_rel    <= n_res_rel;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_rel    <= n_out_rel;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_slot    = r_out_slot;
    assign o_status         = r_out_status;
    assign o_count_after    = r_out_count;
    assign o_entry_released = r_out_rel;

endmodule

// ----- hw/rtl/rpa_table.sv -----
// ----------------------------------------------------------------------------
// rpa_table
// Entry store of the allocator: a synchronous single-port-read, single-port-
// write memory of entries with one valid flop per entry. An entry not
// written since reset or the last clear reads back as all zero.
// ----------------------------------------------------------------------------
module rpa_table #(
    parameter int ENTRIES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_rd_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_rd_addr,
    output rpa_pkg::t_entry                o_rd_entry,
    input  logic                           i_wr_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_wr_addr,
    input  rpa_pkg::t_entry                i_wr_entry
);

    rpa_pkg::t_entry mem [ENTRIES];
    rpa_pkg::t_entry r_rd_data;
    logic            r_rd_ok;
    logic [ENTRIES-1:0] r_valid;

    // Memory array: write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Valid flags: set on write, drop all on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    // Mask entries never written since the last clear
    assign o_rd_entry = r_rd_ok ? r_rd_data : '0;

endmodule

// ----- tb/tb_refcounted_palette_allocator_core.sv -----
// ----------------------------------------------------------------------------
// tb_refcounted_palette_allocator_core
// Self-checking bench for the reference-counted palette allocator. A local
// model of the colour table predicts every result beat. The stimulus is a
// short table of directed operations, then table fills against several error
// slot settings and random traffic over a small colour pool under varying
// back-pressure.
// ----------------------------------------------------------------------------
module tb_refcounted_palette_allocator_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 32;
    localparam int BASE_SLOT    = 224;
    localparam int POOL_SIZE    = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = ENTRIES + 8;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int N_DIRECTED   = 18;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] color;
        logic [7:0]  pslot;
    } t_op;

    typedef struct packed {
        logic [7:0]  slot;
        logic [1:0]  status;
        logic [15:0] count;
        logic        released;
    } t_result;

    typedef struct packed {
        t_op     op;
        logic    typed;
        t_result res;
    } t_dir_row;

    // Directed operations from reset; typed rows carry their own answer
    localparam t_dir_row DIRECTED_OPS [N_DIRECTED] = '{
        '{'{rpa_pkg::FN_FREE_SLOT,  16'h0000, 8'd224}, 1'b1,
          '{8'd224, rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0}},
        '{'{rpa_pkg::FN_FREE_COLOR, 16'h0000, 8'd000}, 1'b1,
          '{8'd0,   rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0}},
        '{'{rpa_pkg::FN_FREE_SLOT,  16'hFFFF, 8'd000}, 1'b1,
          '{8'd0,   rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0}},
        '{'{rpa_pkg::FN_FREE_SLOT,  16'h0000, 8'd223}, 1'b1,
          '{8'd223, rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0}},
        '{'{rpa_pkg::FN_ALLOC,      16'h0000, 8'd255}, 1'b1,
          '{8'd224, rpa_pkg::ST_OK,       16'd1, 1'b0}},
        '{'{rpa_pkg::FN_ALLOC,      16'hFFFF, 8'd000}, 1'b1,
          '{8'd225, rpa_pkg::ST_OK,       16'd1, 1'b0}},
        '{'{rpa_pkg::FN_ALLOC,      16'h0000, 8'd000}, 1'b1,
          '{8'd224, rpa_pkg::ST_OK,       16'd2, 1'b0}},
        '{'{rpa_pkg::FN_FREE_COLOR, 16'hFFFF, 8'd000}, 1'b1,
          '{8'd225, rpa_pkg::ST_OK,       16'd0, 1'b1}},
        '{'{rpa_pkg::FN_FREE_COLOR, 16'hFFFF, 8'd000}, 1'b1,
          '{8'd0,   rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0}},
        '{'{rpa_pkg::FN_ALLOC,      16'h1234, 8'd000}, 1'b0, '0},
        '{'{rpa_pkg::FN_FREE_SLOT,  16'h0000, 8'd224}, 1'b0, '0},
        '{'{rpa_pkg::FN_FREE_SLOT,  16'hFFFF, 8'd224}, 1'b1,
          '{8'd224, rpa_pkg::ST_OK,       16'd0, 1'b1}},
        '{'{rpa_pkg::FN_FREE_SLOT,  16'h0000, 8'd255}, 1'b1,
          '{8'd255, rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0}},
        '{'{rpa_pkg::FN_ALLOC,      16'h0000, 8'd000}, 1'b0, '0},
        '{'{rpa_pkg::FN_FREE_COLOR, 16'h1234, 8'hFF},  1'b1,
          '{8'd225, rpa_pkg::ST_OK,       16'd0, 1'b1}},
        '{'{rpa_pkg::FN_CLEAR,      16'hFFFF, 8'hFF},  1'b1,
          '{8'd0,   rpa_pkg::ST_OK,       16'd0, 1'b0}},
        '{'{rpa_pkg::FN_FREE_COLOR, 16'h0000, 8'd000}, 1'b1,
          '{8'd0,   rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0}},
        '{'{rpa_pkg::FN_ALLOC,      16'hA5A5, 8'hFF},  1'b1,
          '{8'd224, rpa_pkg::ST_OK,       16'd1, 1'b0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        in_valid = 1'b0;
    logic [1:0]  in_func = rpa_pkg::FN_ALLOC;
    logic [15:0] in_color = 16'd0;
    logic [7:0]  in_pslot = 8'd0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_result_slot;
    logic [1:0]  o_status;
    logic [15:0] o_count_after;
    logic        o_entry_released;

    // Local copy of the table and the error slot register
    logic [15:0] pal_color [ENTRIES];
    logic [15:0] pal_count [ENTRIES];
    logic [7:0]  err_slot;

    t_result     expected_q [$];
    logic [15:0] color_pool [POOL_SIZE];
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          err_cnt = 0;
    int          results_seen = 0;
    int          cycle_cnt = 0;

    refcounted_palette_allocator_core #(
        .ENTRIES   (ENTRIES),
        .BASE_SLOT (BASE_SLOT)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (in_func),
        .i_color          (in_color),
        .i_palette_slot   (in_pslot),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_result_slot    (o_result_slot),
        .o_status         (o_status),
        .o_count_after    (o_count_after),
        .o_entry_released (o_entry_released)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Drop one user of an in-use entry, clearing it when the count hits zero
    function automatic t_result release_entry(int idx);
        t_result r;
        r = '0;
        pal_count[idx] = pal_count[idx] - 16'd1;
        if (pal_count[idx] == 16'd0) begin
            pal_color[idx] = 16'd0;
            r.released = 1'b1;
        end
        r.slot   = 8'(BASE_SLOT + idx);
        r.status = rpa_pkg::ST_OK;
        r.count  = pal_count[idx];
        return r;
    endfunction

    // Apply one operation to the local table and return its result beat
    function automatic t_result palette_predict(t_op op);
        t_result    r;
        int         hit;
        int         free_idx;
        logic [7:0] idx;
        r = '0;
        hit = -1;
        free_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (pal_count[i] == 16'd0) begin
                if (free_idx < 0) free_idx = i;
            end else if (pal_color[i] == op.color && hit < 0) begin
                hit = i;
            end
        end
        case (op.func)
            rpa_pkg::FN_ALLOC: begin
                if (hit >= 0) begin
                    if (pal_count[hit] != rpa_pkg::COUNT_MAX)
                        pal_count[hit] = pal_count[hit] + 16'd1;
                    r = '{8'(BASE_SLOT + hit), rpa_pkg::ST_OK, pal_count[hit], 1'b0};
                end else if (free_idx >= 0) begin
                    pal_color[free_idx] = op.color;
                    pal_count[free_idx] = 16'd1;
                    r = '{8'(BASE_SLOT + free_idx), rpa_pkg::ST_OK, 16'd1, 1'b0};
                end else begin
                    r = '{err_slot, rpa_pkg::ST_FULL, 16'd0, 1'b0};
                end
            end
            rpa_pkg::FN_FREE_COLOR: begin
                if (hit >= 0) r = release_entry(hit);
                else r = '{8'd0, rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0};
            end
            rpa_pkg::FN_FREE_SLOT: begin
                idx = op.pslot - 8'(BASE_SLOT);
                if (idx < ENTRIES && pal_count[int'(idx)] != 16'd0)
                    r = release_entry(int'(idx));
                else
                    r = '{op.pslot, rpa_pkg::ST_NO_MATCH, 16'd0, 1'b0};
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    pal_color[i] = 16'd0;
                    pal_count[i] = 16'd0;
                end
            end
        endcase
        return r;
    endfunction

    // Mostly pool colours and in-table slots, with some fully random noise
    function automatic t_op random_op();
        t_op         op;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 48)      op.func = rpa_pkg::FN_ALLOC;
        else if (pick < 70) op.func = rpa_pkg::FN_FREE_COLOR;
        else if (pick < 97) op.func = rpa_pkg::FN_FREE_SLOT;
        else                op.func = rpa_pkg::FN_CLEAR;
        op.color = ($urandom_range(9) < 8) ? color_pool[$urandom_range(POOL_SIZE - 1)]
                                           : 16'($urandom);
        op.pslot = ($urandom_range(9) < 8) ? 8'(BASE_SLOT + $urandom_range(ENTRIES - 1))
                                           : 8'($urandom);
        return op;
    endfunction

    task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
        err_cnt++;
        $display("[%0t] result %0d: %s expected %0d got %0d",
                 $time, results_seen, what, exp_v, got_v);
    endtask

    // Offer one beat, hold it until accepted, then log its expected result
    task automatic send_beat(t_op op, logic typed, t_result typed_res);
        t_result predicted;
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        in_func  <= op.func;
        in_color <= op.color;
        in_pslot <= op.pslot;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = palette_predict(op);
        expected_q.push_back(typed ? typed_res : predicted);
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_error_slot(logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        err_slot = value;
        cfg_we   <= 1'b0;
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) send_beat(random_op(), 1'b0, '0);
    endtask

    // Clear, fill every entry, overflow, then hit a present colour and free a slot
    task automatic fill_table();
        logic [15:0] base;
        base = 16'($urandom);
        send_beat('{rpa_pkg::FN_CLEAR, 16'($urandom), 8'($urandom)}, 1'b0, '0);
        for (int k = 0; k < ENTRIES; k++)
            send_beat('{rpa_pkg::FN_ALLOC, 16'(base + k * 2053), 8'($urandom)}, 1'b0, '0);
        send_beat('{rpa_pkg::FN_ALLOC, 16'(base + 40 * 2053), 8'($urandom)}, 1'b0, '0);
        send_beat('{rpa_pkg::FN_ALLOC, 16'(base + 41 * 2053), 8'($urandom)}, 1'b0, '0);
        send_beat('{rpa_pkg::FN_ALLOC, 16'(base + 5 * 2053), 8'($urandom)}, 1'b0, '0);
        send_beat('{rpa_pkg::FN_FREE_SLOT, 16'($urandom),
                    8'(BASE_SLOT + $urandom_range(ENTRIES - 1))}, 1'b0, '0);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat, slot", 0, 32'(o_result_slot));
            end else begin
                want = expected_q.pop_front();
                if (o_result_slot !== want.slot)
                    report_mismatch("result_slot", 32'(want.slot), 32'(o_result_slot));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_count_after !== want.count)
                    report_mismatch("count_after", 32'(want.count), 32'(o_count_after));
                if (o_entry_released !== want.released)
                    report_mismatch("entry_released", 32'(want.released),
                                    32'(o_entry_released));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            pal_color[i] = 16'd0;
            pal_count[i] = 16'd0;
        end
        err_slot = 8'd185;
        for (int i = 0; i < POOL_SIZE; i++) color_pool[i] = 16'($urandom);
        color_pool[0] = 16'h0000;
        color_pool[1] = 16'hFFFF;

        // Hold reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset error slot
        snd_idle_pct = 14;
        rcv_idle_pct = 59;
        for (int r = 0; r < N_DIRECTED; r++)
            send_beat(DIRECTED_OPS[r].op, DIRECTED_OPS[r].typed, DIRECTED_OPS[r].res);
        fill_table();
        drain();

        // Table-full answers at the error slot extremes
        write_error_slot(8'd0);
        fill_table();
        drain();
        write_error_slot(8'd255);
        fill_table();
        drain();

        // Sender light, receiver heavy; one long hold-off to back up the input
        write_error_slot(8'($urandom));
        hold_req++;
        run_random(160);
        drain();

        // Sender heavy, receiver light
        write_error_slot(8'($urandom));
        snd_idle_pct = 59;
        rcv_idle_pct = 14;
        fill_table();
        run_random(110);
        drain();

        // No idling on either side
        write_error_slot(8'd185);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(110);
        drain();

        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_table.sv
hw/rtl/refcounted_palette_allocator_core.sv
tb/tb_refcounted_palette_allocator_core.sv
